@@ sv/smrs_pkg.sv @@
package smrs_pkg;

   localparam int unsigned DataWidth = 16;
   localparam int unsigned DurWidth  = 30;
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned FuncWidth = 3;
   localparam int unsigned IdxWidth  = 3;
   localparam int unsigned DivWidth  = 34;
   localparam logic [DataWidth-1:0] RateCap = 16'hFFFF;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_NOP   = 3'd0,
      FUNC_MOVE  = 3'd1,
      FUNC_STOP  = 3'd2,
      FUNC_RESET = 3'd3,
      FUNC_TICK  = 3'd4,
      FUNC_RSV5  = 3'd5,
      FUNC_RSV6  = 3'd6,
      FUNC_RSV7  = 3'd7
   } func_type;

   typedef enum logic [IdxWidth-1:0] {
      REG_MIN_PHYS = 3'd0,
      REG_MAX_PHYS = 3'd1,
      REG_MIN_STEP = 3'd2,
      REG_MAX_STEP = 3'd3,
      REG_MIN_RATE = 3'd4,
      REG_MAX_RATE = 3'd5,
      REG_RSV6     = 3'd6,
      REG_RSV7     = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] min_phys;
      logic signed [DataWidth-1:0] max_phys;
      logic signed [DataWidth-1:0] min_step;
      logic signed [DataWidth-1:0] max_step;
      logic [DataWidth-1:0]        min_rate;
      logic [DataWidth-1:0]        max_rate;
   } cfg_type;

   typedef struct packed {
      logic                start;
      logic                neg;
      logic [DivWidth-1:0] num;
      logic [DivWidth-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DivWidth-1:0] quo;
   } div_rsp_type;

   // saturate a signed 35-bit value to 16 bits
   function automatic logic signed [DataWidth-1:0] sat16(input logic signed [DivWidth:0] v);
      logic signed [DataWidth-1:0] r;
      if (v > 35'sd32767) r = 16'sh7FFF;
      else if (v < -35'sd32768) r = 16'sh8000;
      else r = v[DataWidth-1:0];
      return r;
   endfunction

endpackage

@@ sv/smrs_if.sv @@
interface smrs_req_if;
   import smrs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [FuncWidth-1:0] func;
   logic signed [DataWidth-1:0] target_value;
   logic [DurWidth-1:0]  duration_ms;
   logic [TimeWidth-1:0] now_ms;
   modport source(output valid, func, target_value, duration_ms, now_ms, input ready);
   modport sink(input valid, func, target_value, duration_ms, now_ms, output ready);
endinterface

interface smrs_rsp_if;
   import smrs_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] current_phys;
   logic signed [DataWidth-1:0] current_pos;
   logic signed [DataWidth-1:0] requested_phys;
   logic [DurWidth-1:0]         requested_ms;
   logic [DataWidth-1:0]        rate_now;
   logic                        was_capped;
   modport source(output valid, current_phys, current_pos, requested_phys, requested_ms,
                  rate_now, was_capped, input ready);
   modport sink(input valid, current_phys, current_pos, requested_phys, requested_ms,
                rate_now, was_capped, output ready);
endinterface

interface smrs_csr_if;
   import smrs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [IdxWidth-1:0]  index;
   logic [DataWidth-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ sv/smrs_div.sv @@
// Shared restoring divider: one quotient bit a cycle on magnitudes,
// sign applied at the end (truncation toward zero).
module smrs_div
   import smrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   localparam int unsigned CntWidth = $clog2(DivWidth + 1);

   logic [DivWidth-1:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [DivWidth:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DivWidth-1]} - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         neg_in  = req.neg;
         cnt_in  = CntWidth'(DivWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DivWidth]) begin
            rem_in = trial[DivWidth-1:0];
            quo_in = {quo_ff[DivWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DivWidth-2:0], quo_ff[DivWidth-1]};
            quo_in = {quo_ff[DivWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
endmodule

@@ sv/smrs_regs.sv @@
// Configuration register file
module smrs_regs
   import smrs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   smrs_csr_if.sink  csr,
   output cfg_type   cfg
);
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (reg_idx_type'(csr.index))
            REG_MIN_PHYS: cfg_in.min_phys = csr.data;
            REG_MAX_PHYS: cfg_in.max_phys = csr.data;
            REG_MIN_STEP: cfg_in.min_step = csr.data;
            REG_MAX_STEP: cfg_in.max_step = csr.data;
            REG_MIN_RATE: cfg_in.min_rate = csr.data;
            REG_MAX_RATE: cfg_in.max_rate = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else cfg_ff <= cfg_in;
   end

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;
endmodule

@@ sv/smrs_ctrl.sv @@
// Sequencer: issues up to three divisions per item through the shared divider
module smrs_ctrl
   import smrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   smrs_req_if.sink    req,
   smrs_rsp_if.source  rsp,
   output div_req_type dreq,
   input  div_rsp_type drsp
);
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MAPG = 7'b0000010,
      ST_RATE = 7'b0000100,
      ST_TICK = 7'b0001000,
      ST_MAPP = 7'b0010000,
      ST_WAIT = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   localparam int unsigned W = DivWidth;

   state_type state_ff, state_in;
   logic signed [DataWidth-1:0] pos_ff, pos_in, gstep_ff, gstep_in, gphys_ff, gphys_in;
   logic signed [DataWidth-1:0] phys_ff, phys_in;
   logic [DurWidth-1:0]  gms_ff, gms_in;
   logic [DataWidth-1:0] rate_ff, rate_in;
   logic [TimeWidth-1:0] last_ff, last_in, elapsed_ff, elapsed_in;
   logic                 cap_ff, cap_in, vld_ff, vld_in;
   state_type            next_ff, next_in;
   logic signed [DataWidth-1:0] y0_ff, y0_in;
   div_req_type          dreq_in;

   // shared map helpers
   logic signed [DataWidth:0]   mx, sx, sy;
   logic signed [2*DataWidth+1:0] mprod;
   logic signed [W:0]           qs, pnext;
   logic [W-1:0]                rq;
   logic signed [DataWidth:0]   gap;
   logic [TimeWidth-1:0]        el;
   logic signed [DataWidth:0]   tgt;

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff; gstep_in = gstep_ff; gphys_in = gphys_ff; phys_in = phys_ff;
      gms_in = gms_ff; rate_in = rate_ff; last_in = last_ff; elapsed_in = elapsed_ff;
      cap_in = cap_ff; vld_in = vld_ff; next_in = next_ff; y0_in = y0_ff;
      dreq_in = '0;
      mx = '0; sx = '0; sy = '0; mprod = '0;
      qs = {drsp.quo[W-1], drsp.quo};
      pnext = '0; rq = '0; gap = '0; el = '0; tgt = '0;
      if (vld_ff && rsp.ready) vld_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               unique case (func_type'(req.func))
                  FUNC_MOVE: begin
                     gms_in = req.duration_ms;
                     tgt = (DataWidth+1)'(req.target_value);
                     cap_in = 1'b0;
                     if (req.target_value < cfg.min_phys) begin
                        tgt = cfg.min_phys; cap_in = 1'b1;
                     end
                     if (tgt > cfg.max_phys) begin
                        tgt = cfg.max_phys; cap_in = 1'b1;
                     end
                     gphys_in = tgt[DataWidth-1:0];
                     // map physical goal to steps
                     sx = cfg.max_phys - cfg.min_phys;
                     sy = cfg.max_step - cfg.min_step;
                     mx = tgt - cfg.min_phys;
                     mprod = mx * sy;
                     y0_in = cfg.min_step;
                     if (sx == '0) begin
                        gstep_in = cfg.min_step;
                        state_in = ST_RATE;
                        dreq_in.start = 1'b0;
                     end else begin
                        dreq_in.start = 1'b1;
                        dreq_in.neg = mprod[2*DataWidth+1] ^ sx[DataWidth];
                        dreq_in.num = W'(mprod[2*DataWidth+1] ? -mprod : mprod);
                        dreq_in.den = W'(sx[DataWidth] ? -sx : sx);
                        next_in = ST_MAPG;
                        state_in = ST_WAIT;
                     end
                  end
                  FUNC_STOP: begin
                     rate_in = '0; state_in = ST_MAPP;
                  end
                  FUNC_RESET: begin
                     pos_in = req.target_value; gstep_in = req.target_value;
                     rate_in = '0; state_in = ST_MAPP;
                  end
                  FUNC_TICK: begin
                     if (last_ff == '0) begin
                        last_in = req.now_ms; state_in = ST_MAPP;
                     end else begin
                        el = (req.now_ms - last_ff) << 2;
                        last_in = req.now_ms;
                        if (el == '0) el = TimeWidth'(1);
                        if (rate_ff == '0) state_in = ST_MAPP;
                        else if (pos_ff == gstep_ff) begin
                           rate_in = '0; state_in = ST_MAPP;
                        end else begin
                           // nonzero elapsed marks a step count in the result stage
                           elapsed_in = el;
                           dreq_in.start = 1'b1;
                           dreq_in.num = W'(el);
                           dreq_in.den = W'(rate_ff);
                           next_in = ST_TICK;
                           state_in = ST_WAIT;
                        end
                     end
                  end
                  default: state_in = ST_MAPP;
               endcase
            end
         end
         ST_WAIT: if (drsp.done) state_in = next_ff;
         ST_MAPG: begin
            gstep_in = sat16(qs + W'(signed'(y0_ff)));
            state_in = ST_RATE;
         end
         ST_RATE: begin
            gap = (gstep_ff > pos_ff) ? gstep_ff - pos_ff : pos_ff - gstep_ff;
            if (gap == '0) begin
               rate_in = cfg.min_rate;
               if (cfg.min_rate > cfg.max_rate) rate_in = cfg.max_rate;
               state_in = ST_MAPP;
            end else begin
               dreq_in.start = 1'b1;
               dreq_in.num = W'({gms_ff, 2'b00});
               dreq_in.den = W'(gap);
               next_in = ST_TICK;
               state_in = ST_WAIT;
            end
         end
         ST_TICK: begin
            // shared result stage: rate for move, step count for tick
            rq = drsp.quo;
            if (elapsed_ff == '0) begin
               if (rq < W'(cfg.min_rate)) rq = W'(cfg.min_rate);
               if (rq > W'(cfg.max_rate)) rq = W'(cfg.max_rate);
               rate_in = rq[DataWidth-1:0];
            end else begin
               if (rq == '0) rq = W'(1);
               if (pos_ff < gstep_ff) begin
                  pnext = W'(signed'(pos_ff)) + signed'({1'b0, rq});
                  if (pnext > W'(signed'(gstep_ff))) pnext = W'(signed'(gstep_ff));
               end else begin
                  pnext = W'(signed'(pos_ff)) - signed'({1'b0, rq});
                  if (pnext < W'(signed'(gstep_ff))) pnext = W'(signed'(gstep_ff));
               end
               if (pnext > W'(signed'(cfg.max_step))) pnext = W'(signed'(cfg.max_step));
               if (pnext < W'(signed'(cfg.min_step))) pnext = W'(signed'(cfg.min_step));
               pos_in = pnext[DataWidth-1:0];
            end
            elapsed_in = '0;
            state_in = ST_MAPP;
         end
         ST_MAPP: begin
            // map step position back to physical units
            sx = cfg.max_step - cfg.min_step;
            sy = cfg.max_phys - cfg.min_phys;
            mx = pos_ff - cfg.min_step;
            mprod = mx * sy;
            y0_in = cfg.min_phys;
            if (sx == '0) begin
               phys_in = cfg.min_phys;
               vld_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               dreq_in.start = 1'b1;
               dreq_in.neg = mprod[2*DataWidth+1] ^ sx[DataWidth];
               dreq_in.num = W'(mprod[2*DataWidth+1] ? -mprod : mprod);
               dreq_in.den = W'(sx[DataWidth] ? -sx : sx);
               next_in = ST_OUT;
               state_in = ST_WAIT;
            end
         end
         ST_OUT: begin
            if (next_ff == ST_OUT && !vld_ff) begin
               phys_in = sat16(qs + W'(signed'(y0_ff)));
               vld_in = 1'b1;
               next_in = ST_IDLE;
            end else if (vld_ff && rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; vld_ff <= 1'b0;
         pos_ff <= '0; gstep_ff <= '0; gphys_ff <= '0; gms_ff <= '0;
         rate_ff <= '0; last_ff <= '0; cap_ff <= 1'b0; elapsed_ff <= '0;
         next_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in; vld_ff <= vld_in;
         pos_ff <= pos_in; gstep_ff <= gstep_in; gphys_ff <= gphys_in; gms_ff <= gms_in;
         rate_ff <= rate_in; last_ff <= last_in; cap_ff <= cap_in; elapsed_ff <= elapsed_in;
         next_ff <= next_in;
      end
      phys_ff <= phys_in;
      y0_ff   <= y0_in;
   end

   assign dreq = dreq_in;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = vld_ff;
   assign rsp.current_phys   = phys_ff;
   assign rsp.current_pos    = pos_ff;
   assign rsp.requested_phys = gphys_ff;
   assign rsp.requested_ms   = gms_ff;
   assign rsp.rate_now       = rate_ff;
   assign rsp.was_capped     = cap_ff;
endmodule

@@ sv/stepper_move_rate_simulator.sv @@
// The result is worked out through the shared 34-bit divider: each division
// yields 34 quotient bits and then raises done. A move uses up to three
// divisions, a tick up to two, other requests at most one.
// Throughput: one request at a time; ready is low until the result is taken.
// Reset (synchronous, active high) returns the sequencer to idle and clears config and control registers.
module stepper_move_rate_simulator
   import smrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   smrs_req_if.sink   req,
   smrs_rsp_if.source rsp,
   smrs_csr_if.sink   csr
);
   cfg_type     cfg;
   div_req_type dreq;
   div_rsp_type drsp;

   smrs_regs u_regs (.clock, .reset, .csr, .cfg);
   smrs_div  u_div  (.clock, .reset, .req(dreq), .rsp(drsp));
   smrs_ctrl u_ctrl (.clock, .reset, .cfg, .req, .rsp, .dreq, .drsp);
endmodule

@@ sv/smrs_checker.sv @@
module smrs_checker
   import smrs_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [DataWidth-1:0] rsp_rate_now
);
   // no new request while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while result pending");
   // no result in the cycle after a request is taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");
   // result holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rate_now)))
      else $error("result dropped");
   // after reset the block is idle
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind stepper_move_rate_simulator smrs_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_rate_now(rsp.rate_now)
);

@@ sim/smrs_tb_if.sv @@
// Testbench-side copies are not needed: the block's own interfaces are used.
// This file holds small request and status records shared by driver, stimulus and monitor.
package smrs_tb_pkg;
   import smrs_pkg::*;

   typedef struct {
      func_type                    func;
      logic signed [DataWidth-1:0] target_value;
      logic [DurWidth-1:0]         duration_ms;
      logic [TimeWidth-1:0]        now_ms;
   } request_type;

   typedef struct {
      logic signed [DataWidth-1:0] current_phys;
      logic signed [DataWidth-1:0] current_pos;
      logic signed [DataWidth-1:0] requested_phys;
      logic [DurWidth-1:0]         requested_ms;
      logic [DataWidth-1:0]        rate_now;
      logic                        was_capped;
   } status_type;
endpackage

@@ sim/stepper_move_rate_simulator_test.sv @@
module stepper_move_rate_simulator_test;
   import smrs_pkg::*;
   import smrs_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   smrs_req_if req ();
   smrs_rsp_if rsp ();
   smrs_csr_if csr ();

   stepper_move_rate_simulator i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always #5 clock = ~clock;

   // predictor state
   int    lim_min_phys, lim_max_phys, lim_min_step, lim_max_step;
   longint unsigned lim_min_rate, lim_max_rate;
   int    pos_steps, goal_steps, goal_phys_val;
   longint unsigned goal_dur, step_period, clock_seen, capped_bit;

   request_type pending_requests[$];
   status_type  expected_status[$];
   int  errors;
   int  quiet_cycles;
   bit  stim_done;
   bit  idle_enable;
   int  send_gap, take_stall;

   function automatic int clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   // y0 + (x-x0)*(y1-y0)/(x1-x0), truncating, saturated
   function automatic int map_line(int x, int x0, int x1, int y0, int y1);
      longint den, num;
      den = longint'(x1) - x0;
      if (den == 0) return y0;
      num = (longint'(x) - x0) * (longint'(y1) - y0);
      return clip16(longint'(y0) + num / den);
   endfunction

   function automatic void predict_reset();
      lim_min_phys = 0; lim_max_phys = 0; lim_min_step = 0; lim_max_step = 0;
      lim_min_rate = 0; lim_max_rate = 0;
      pos_steps = 0; goal_steps = 0; goal_phys_val = 0;
      goal_dur = 0; step_period = 0; clock_seen = 0; capped_bit = 0;
   endfunction

   function automatic void predict_csr(reg_idx_type idx, logic [15:0] val);
      case (idx)
         REG_MIN_PHYS: lim_min_phys = int'($signed(val));
         REG_MAX_PHYS: lim_max_phys = int'($signed(val));
         REG_MIN_STEP: lim_min_step = int'($signed(val));
         REG_MAX_STEP: lim_max_step = int'($signed(val));
         REG_MIN_RATE: lim_min_rate = val;
         REG_MAX_RATE: lim_max_rate = val;
         default: ;
      endcase
   endfunction

   // work out the status a request produces
   function automatic status_type predict_status(request_type r);
      status_type s;
      int tgt, p;
      longint unsigned span, rate, elapsed, moves;
      longint np;
      bit up;
      case (r.func)
         FUNC_MOVE: begin
            tgt = r.target_value;
            goal_dur = r.duration_ms;
            capped_bit = 0;
            if (tgt < lim_min_phys) begin tgt = lim_min_phys; capped_bit = 1; end
            if (tgt > lim_max_phys) begin tgt = lim_max_phys; capped_bit = 1; end
            goal_phys_val = tgt;
            goal_steps = map_line(tgt, lim_min_phys, lim_max_phys, lim_min_step, lim_max_step);
            span = (goal_steps > pos_steps) ? goal_steps - pos_steps : pos_steps - goal_steps;
            rate = lim_min_rate;
            if (span != 0) rate = (goal_dur * 4) / span;
            if (rate < lim_min_rate) rate = lim_min_rate;
            if (rate > lim_max_rate) rate = lim_max_rate;
            if (rate > 64'hFFFF) rate = 64'hFFFF;
            step_period = rate;
         end
         FUNC_STOP: step_period = 0;
         FUNC_RESET: begin
            goal_steps = r.target_value;
            pos_steps = r.target_value;
            step_period = 0;
         end
         FUNC_TICK: begin
            if (clock_seen == 0) clock_seen = r.now_ms;
            else begin
               elapsed = ((r.now_ms - clock_seen) * 4) & 64'hFFFF_FFFF;
               if (elapsed == 0) elapsed = 1;
               clock_seen = r.now_ms;
               if (step_period != 0) begin
                  if (pos_steps == goal_steps) step_period = 0;
                  else begin
                     moves = elapsed / step_period;
                     if (moves == 0) moves = 1;
                     up = pos_steps < goal_steps;
                     np = up ? longint'(pos_steps) + longint'(moves)
                             : longint'(pos_steps) - longint'(moves);
                     if (up && np > goal_steps) np = goal_steps;
                     if (!up && np < goal_steps) np = goal_steps;
                     if (np > lim_max_step) np = lim_max_step;
                     if (np < lim_min_step) np = lim_min_step;
                     pos_steps = int'(np);
                  end
               end
            end
         end
         default: ;
      endcase
      p = map_line(pos_steps, lim_min_step, lim_max_step, lim_min_phys, lim_max_phys);
      s.current_phys   = p[15:0];
      s.current_pos    = pos_steps[15:0];
      s.requested_phys = goal_phys_val[15:0];
      s.requested_ms   = goal_dur[29:0];
      s.rate_now       = step_period[15:0];
      s.was_capped     = capped_bit[0];
      return s;
   endfunction

   // request driver
   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         req.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) expected_status.push_back(predict_status(pending_requests.pop_front()));
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            r = pending_requests[0];
            req.valid        <= 1'b1;
            req.func         <= r.func;
            req.target_value <= r.target_value;
            req.duration_ms  <= r.duration_ms;
            req.now_ms       <= r.now_ms;
            if (idle_enable && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 5);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // result monitor and back-pressure
   always @(posedge clock) begin
      status_type e;
      if (reset) begin
         rsp.ready  <= 1'b0;
         take_stall <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected status pos=%0d", $time, rsp.current_pos);
               errors++;
            end else begin
               e = expected_status.pop_front();
               if (rsp.current_phys !== e.current_phys) begin
                  $display("%0t: current_phys exp %0d got %0d", $time, e.current_phys,
                           rsp.current_phys);
                  errors++;
               end
               if (rsp.current_pos !== e.current_pos) begin
                  $display("%0t: current_pos exp %0d got %0d", $time, e.current_pos,
                           rsp.current_pos);
                  errors++;
               end
               if (rsp.requested_phys !== e.requested_phys) begin
                  $display("%0t: requested_phys exp %0d got %0d", $time, e.requested_phys,
                           rsp.requested_phys);
                  errors++;
               end
               if (rsp.requested_ms !== e.requested_ms) begin
                  $display("%0t: requested_ms exp %0d got %0d", $time, e.requested_ms,
                           rsp.requested_ms);
                  errors++;
               end
               if (rsp.rate_now !== e.rate_now) begin
                  $display("%0t: rate_now exp %0d got %0d", $time, e.rate_now, rsp.rate_now);
                  errors++;
               end
               if (rsp.was_capped !== e.was_capped) begin
                  $display("%0t: was_capped exp %0d got %0d", $time, e.was_capped,
                           rsp.was_capped);
                  errors++;
               end
            end
         end
         if (take_stall > 0) begin
            take_stall <= take_stall - 1;
            rsp.ready  <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            take_stall <= $urandom_range(0, 4);
            rsp.ready  <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic add_request(func_type f, int tv, longint unsigned dur, longint unsigned now);
      request_type r;
      r.func = f;
      r.target_value = tv[15:0];
      r.duration_ms = dur[29:0];
      r.now_ms = now[31:0];
      pending_requests.push_back(r);
   endtask

   // wait until every request has its status back, plus block drain time
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req.valid || expected_status.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // valid stays high across back-to-back writes; write_limits drops it
   task automatic write_csr(reg_idx_type idx, logic [15:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      predict_csr(idx, val);
   endtask

   task automatic write_limits(int p0, int p1, int s0, int s1, int r0, int r1);
      write_csr(REG_MIN_PHYS, p0[15:0]);
      write_csr(REG_MAX_PHYS, p1[15:0]);
      write_csr(REG_MIN_STEP, s0[15:0]);
      write_csr(REG_MAX_STEP, s1[15:0]);
      write_csr(REG_MIN_RATE, r0[15:0]);
      write_csr(REG_MAX_RATE, r1[15:0]);
      csr.valid <= 1'b0;
   endtask

   // a burst of random requests: moves, millisecond ticks, stops, resets, NOPs and reserved codes
   task automatic random_phase(int count);
      longint unsigned ms;
      ms = $urandom_range(1, 1000);
      repeat (count) begin
         case ($urandom_range(0, 19))
            0, 1, 2: add_request(FUNC_MOVE, $urandom_range(0, 65535),
                                 $urandom_range(0, 3) == 0 ? {$urandom} & 30'h3FFF_FFFF
                                                           : $urandom_range(0, 2000), 0);
            3: add_request(FUNC_STOP, $urandom, $urandom, $urandom);
            4: add_request(FUNC_RESET, $urandom_range(0, 65535), $urandom, $urandom);
            5: add_request(func_type'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
            6: add_request(FUNC_NOP, $urandom, $urandom, $urandom);
            7: begin
               ms = $urandom;
               add_request(FUNC_TICK, $urandom, $urandom, ms);
            end
            default: begin
               ms = (ms + $urandom_range(0, 40)) & 64'hFFFF_FFFF;
               add_request(FUNC_TICK, $urandom, $urandom, ms);
            end
         endcase
      end
   endtask

   initial begin
      errors = 0;
      stim_done = 0;
      idle_enable = 1;
      predict_reset();
      req.valid = 1'b0;
      req.func = FUNC_NOP;
      req.target_value = '0;
      req.duration_ms = '0;
      req.now_ms = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = REG_MIN_PHYS;
      csr.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: limits crossing zero, moves to extremes, tick special cases, stop, resets, reserved codes
      write_limits(-1000, 1000, -200, 200, 2, 400);
      add_request(FUNC_MOVE, 32767, 100, 0);
      add_request(FUNC_MOVE, -32768, 30'h3FFF_FFFF, 0);
      add_request(FUNC_TICK, -1, 30'h3FFF_FFFF, 0);
      add_request(FUNC_TICK, 0, 0, 5);
      add_request(FUNC_TICK, 0, 0, 5);
      add_request(FUNC_TICK, 0, 0, 32'hFFFF_FFFF);
      add_request(FUNC_TICK, 0, 0, 2000);
      add_request(FUNC_MOVE, 500, 0, 0);
      add_request(FUNC_TICK, 0, 0, 2001);
      add_request(FUNC_TICK, 0, 0, 32'hFFFF_FFF0);
      add_request(FUNC_TICK, 0, 0, 3);
      add_request(FUNC_TICK, 0, 0, 4);
      add_request(FUNC_STOP, 0, 0, 0);
      add_request(FUNC_RESET, 32767, 0, 0);
      add_request(FUNC_MOVE, 0, 10, 0);
      add_request(FUNC_TICK, 0, 0, 100);
      add_request(FUNC_RESET, -32768, 0, 0);
      add_request(FUNC_RSV5, 0, 0, 0);
      add_request(FUNC_RSV6, 0, 0, 0);
      add_request(FUNC_RSV7, 0, 0, 0);
      add_request(FUNC_NOP, 0, 0, 0);
      wait_drained();

      // crossed and extreme limits, zero rate
      write_limits(32767, -32768, 32767, -32768, 65535, 0);
      add_request(FUNC_MOVE, 0, 1000, 0);
      add_request(FUNC_TICK, 0, 0, 10);
      add_request(FUNC_TICK, 0, 0, 11);
      random_phase(60);
      wait_drained();

      write_limits(-32768, 32767, -32768, 32767, 0, 65535);
      random_phase(90);
      wait_drained();

      write_limits(5, 5, -50, 70, 1, 3);
      random_phase(60);
      wait_drained();

      write_limits(-300, 300, 300, -300, 0, 1000);
      random_phase(100);
      wait_drained();

      // last part without idling
      idle_enable = 0;
      write_limits($urandom_range(0, 65535), $urandom_range(0, 65535), -4000, 4000,
                   $urandom_range(0, 20), $urandom_range(0, 65535));
      random_phase(110);
      wait_drained();

      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
